FILE: src/sorted_key_table_assert.svh
// Assertion macros shared by the sorted key table RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define SKT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/skt_pkg.sv
// Shared types and constants of the sorted key table.
// No dependencies; imported by the top level.
package skt_pkg;

  localparam int unsigned KeyW        = 44;
  localparam int unsigned OpW         = 2;
  localparam int unsigned PosW        = 6;
  localparam int unsigned StatW       = 2;
  localparam int unsigned EntW        = 7;
  localparam int unsigned CapacityDef = 64;

  // request codes; the unused code is served as a lookup
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatW-1:0] ST_DUP     = 2'd1;
  localparam logic [StatW-1:0] ST_MISSING = 2'd2;
  localparam logic [StatW-1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_CHECK,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD
  } state_e;

endpackage

FILE: src/sorted_key_table.sv
// Sorted key table top level: ordered key store with insert, lookup, delete.
// Depends on skt_pkg, skt_ram and sorted_key_table_assert.svh.
// Steps: a search of n keys alternates probe and compare steps, then
//   checks the hit (skipped when the key is above every entry) and
//   decides; an insert moves each entry up with a read and a write, then
//   writes the key; a delete moves each entry down in one read-ahead,
//   write-behind step, then finishes; the result strobe is registered from
//   the final step. All of it is bound by the single RAM port pair.
// Throughput: one request at a time; busy is high from acceptance to the
//   result. The receiver cannot stall. Reset clears control and the key
//   count only; the key store needs no clearing pass.
module sorted_key_table #(
  parameter int unsigned Capacity = skt_pkg::CapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [skt_pkg::OpW-1:0]   op_i,
  input  logic [skt_pkg::KeyW-1:0]  key_i,
  output logic                      done_o,
  output logic                      found_o,
  output logic [skt_pkg::PosW-1:0]  position_o,
  output logic [skt_pkg::StatW-1:0] status_o,
  output logic [skt_pkg::EntW-1:0]  entries_o
);

  import skt_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  state_e state_q, state_d;

  // request and search registers
  logic [OpW-1:0]   op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [CntW-1:0]  lo_q, lo_d;    // lower bound of the search window
  logic [CntW-1:0]  hi_q, hi_d;    // upper bound (exclusive)
  logic [CntW-1:0]  idx_q, idx_d;  // shift cursor
  logic [CntW-1:0]  cnt_q, cnt_d;  // occupied entries
  logic             hit_q, hit_d;

  // result registers
  logic             done_q, done_d;
  logic             res_found_q, res_found_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;
  logic [StatW-1:0] res_stat_q, res_stat_d;
  logic [EntW-1:0]  res_ent_q, res_ent_d;

  // RAM port
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [KeyW-1:0]  ram_wdata, ram_rdata;

  logic [CntW-1:0]  mid;
  logic [CntW-1:0]  idx_dn;
  logic [CntW-1:0]  idx_up;
  logic             win_open;
  logic             is_full;
  logic             key_less;

  // finish bundle
  logic             fin;
  logic             fin_found;
  logic [CntW-1:0]  fin_pos;
  logic [StatW-1:0] fin_stat;
  logic [CntW-1:0]  fin_cnt;
  logic [CntW+PosW-1:0] fin_pos_ext;
  logic [CntW+EntW-1:0] fin_cnt_ext;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_dn   = idx_q - CntW'(1);
  assign idx_up   = idx_q + CntW'(1);
  assign win_open = (lo_q < hi_q);
  assign is_full  = (cnt_q == CntW'(Capacity));
  // the less-than comparator of the binary search
  assign key_less = (ram_rdata < key_q);

  skt_ram #(
    .Width (KeyW),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_PROBE;
      end
      S_PROBE: begin
        if (win_open) begin
          state_d = S_CMP;
        end else if (lo_q < cnt_q) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CMP:   state_d = S_PROBE;
      S_CHECK: state_d = S_DECIDE;
      S_DECIDE: begin
        if (op_q == OP_INSERT && !hit_q && !is_full) begin
          state_d = S_UP_RD;
        end else if (op_q == OP_DELETE && hit_q) begin
          state_d = S_DN_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_UP_RD: begin
        if (idx_q > lo_q) state_d = S_UP_WR;
        else              state_d = S_IDLE;
      end
      S_UP_WR: state_d = S_UP_RD;
      S_DN_RD: begin
        // one state does both halves of a down move: read ahead, write behind
        if (idx_up < cnt_q) state_d = S_DN_RD;
        else                state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, RAM control and results
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    done_d      = 1'b0;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    res_stat_d  = res_stat_q;
    res_ent_d   = res_ent_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AddrW-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = mid[AddrW-1:0];
    fin         = 1'b0;
    fin_found   = hit_q;
    fin_pos     = '0;
    fin_stat    = ST_DONE;
    fin_cnt     = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d  = op_i;
          key_d = key_i;
          lo_d  = '0;
          hi_d  = cnt_q;
          hit_d = 1'b0;
        end
      end
      S_PROBE: begin
        if (win_open) begin
          ram_re = 1'b1;
        end else if (lo_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = lo_q[AddrW-1:0];
        end
      end
      S_CMP: begin
        if (key_less) lo_d = mid + CntW'(1);
        else          hi_d = mid;
      end
      S_CHECK: begin
        hit_d = (ram_rdata == key_q);
      end
      S_DECIDE: begin
        if (op_q == OP_INSERT) begin
          if (hit_q) begin
            fin      = 1'b1;
            fin_pos  = lo_q;
            fin_stat = ST_DUP;
          end else if (is_full) begin
            fin      = 1'b1;
            fin_stat = ST_FULL;
          end else begin
            idx_d = cnt_q;
          end
        end else if (op_q == OP_DELETE) begin
          if (hit_q) begin
            idx_d = lo_q;
          end else begin
            fin      = 1'b1;
            fin_stat = ST_MISSING;
          end
        end else begin
          fin      = 1'b1;
          fin_pos  = hit_q ? lo_q : '0;
          fin_stat = hit_q ? ST_DONE : ST_MISSING;
        end
      end
      S_UP_RD: begin
        if (idx_q > lo_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dn[AddrW-1:0];
        end else begin
          // gap is open at the insert point
          ram_we    = 1'b1;
          ram_waddr = lo_q[AddrW-1:0];
          ram_wdata = key_q;
          cnt_d     = cnt_q + CntW'(1);
          fin       = 1'b1;
          fin_pos   = lo_q;
          fin_cnt   = cnt_q + CntW'(1);
        end
      end
      S_UP_WR: begin
        ram_we = 1'b1;
        idx_d  = idx_dn;
      end
      S_DN_RD: begin
        // write the entry read last cycle one place down, skipped on entry
        if (idx_q != lo_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_dn[AddrW-1:0];
        end
        if (idx_up < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_up[AddrW-1:0];
          idx_d     = idx_up;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          fin     = 1'b1;
          fin_pos = lo_q;
          fin_cnt = cnt_q - CntW'(1);
        end
      end
      default: ;
    endcase

    fin_pos_ext = {{PosW{1'b0}}, fin_pos};
    fin_cnt_ext = {{EntW{1'b0}}, fin_cnt};
    if (fin) begin
      done_d      = 1'b1;
      res_found_d = fin_found;
      res_pos_d   = fin_pos_ext[PosW-1:0];
      res_stat_d  = fin_stat;
      res_ent_d   = fin_cnt_ext[EntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    idx_q       <= idx_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    res_stat_q  <= res_stat_d;
    res_ent_q   <= res_ent_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign found_o    = res_found_q;
  assign position_o = res_pos_q;
  assign status_o   = res_stat_q;
  assign entries_o  = res_ent_q;

`include "sorted_key_table_assert.svh"

  `SKT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "item accepted but not busy")
  `SKT_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held two cycles")
  `SKT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntW'(Capacity), "key count above capacity")
  `SKT_ASSERT_IMPL(a_full_clean, done_o && status_o == ST_FULL, !found_o && position_o == '0, "full result not clean")
  `SKT_ASSERT_IMPL(a_dup_found, done_o && status_o == ST_DUP, found_o, "duplicate without hit")

endmodule

FILE: src/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
